/* rtl/core/tsss_pkg.sv */
// shared types, codes and constants for the temperature sample scheduler
// no dependencies; used by the scheduler core and its step logic

package tsss_pkg;

  // phase codes
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_CONV  = 2'd1,
    PH_READY = 2'd2
  } phase_t;

  // item selector codes
  typedef enum logic [1:0] {
    FN_POLL    = 2'd0,
    FN_REQUEST = 2'd1,
    FN_READ    = 2'd2
  } func_t;

  // configuration register indexes
  localparam logic CFG_PERIOD     = 1'b0;
  localparam logic CFG_RESOLUTION = 1'b1;

  localparam int PERIOD_W  = 31;
  localparam int RES_W     = 4;
  localparam int TIME_W    = 32;
  localparam int TEMP_W    = 12;
  localparam int COUNT_W   = 32;
  localparam int DELAY_W   = 10;

  localparam logic [RES_W-1:0] RES_MIN   = 4'd9;
  localparam logic [RES_W-1:0] RES_MAX   = 4'd12;
  localparam logic [RES_W-1:0] RES_RESET = 4'd12;

  // disconnected code (-127 C) and the 85 C power-on value, in 1/16 C
  localparam logic signed [TEMP_W-1:0] T_DISCONNECTED = -12'sd2032;
  localparam logic signed [TEMP_W-1:0] T_EIGHTYFIVE   = 12'sd1360;

  localparam logic [DELAY_W-1:0] MARGIN_MS = 10'd5;

  typedef struct packed {
    phase_t                     phase;
    logic [TIME_W-1:0]          request_time;
    logic [TIME_W-1:0]          ready_time;
    logic signed [TEMP_W-1:0]   last_temp;
    logic                       have_value;
    logic                       fresh;
    logic [COUNT_W-1:0]         good_count;
    logic [COUNT_W-1:0]         error_count;
  } tsss_state_t;

  typedef struct packed {
    logic [COUNT_W-1:0]         error_count;
    logic [COUNT_W-1:0]         good_count;
    logic                       fresh;
    logic                       value_valid;
    logic signed [TEMP_W-1:0]   temp_value;
    logic                       sample_accepted;
    logic                       start_conversion;
    logic [1:0]                 phase;
  } tsss_result_t;

  // conversion time plus settling margin, per resolution
  function automatic logic [DELAY_W-1:0] due_delay(input logic [RES_W-1:0] bits);
    logic [DELAY_W-1:0] conv;
    case (bits)
      4'd9:    conv = 10'd94;
      4'd10:   conv = 10'd188;
      4'd11:   conv = 10'd375;
      default: conv = 10'd750;
    endcase
    return conv + MARGIN_MS;
  endfunction

  // wrap-safe: (signed)(a - b) >= lim, lim non-negative
  function automatic logic elapsed(input logic [TIME_W-1:0]   a,
                                   input logic [TIME_W-1:0]   b,
                                   input logic [PERIOD_W-1:0] lim);
    logic [TIME_W-1:0] d;
    d = a - b;
    return !d[TIME_W-1] && (d[TIME_W-2:0] >= lim);
  endfunction

  // clamp a written resolution into 9..12
  function automatic logic [RES_W-1:0] clamp_res(input logic [RES_W-1:0] v);
    logic [RES_W-1:0] r;
    r = v;
    if (v < RES_MIN) r = RES_MIN;
    if (v > RES_MAX) r = RES_MAX;
    return r;
  endfunction

endpackage

/* rtl/core/tsss_step.sv */
// next-state and result logic for one item of the sample scheduler
// depends on tsss_pkg

module tsss_step
  import tsss_pkg::*;
(
  input  tsss_state_t               cur,
  input  logic [PERIOD_W-1:0]       period_ms,
  input  logic [RES_W-1:0]          resolution_bits,
  input  logic [1:0]                func,
  input  logic [TIME_W-1:0]         now_ms,
  input  logic signed [TEMP_W-1:0]  sample_temp,
  output tsss_state_t               nxt,
  output tsss_result_t              res
);

  logic              started;
  logic              accepted;
  logic [TIME_W-1:0] due_time;

  assign due_time = now_ms + TIME_W'(due_delay(resolution_bits));

  always_comb begin
    nxt      = cur;
    started  = 1'b0;
    accepted = 1'b0;
    case (func_t'(func))
      FN_POLL: begin
        if (cur.phase == PH_CONV) begin
          if (elapsed(now_ms, cur.ready_time, '0)) begin
            if (sample_temp == T_DISCONNECTED || sample_temp == T_EIGHTYFIVE) begin
              nxt.error_count = cur.error_count + COUNT_W'(1);
              nxt.phase       = PH_IDLE;
            end else begin
              nxt.last_temp  = sample_temp;
              nxt.have_value = 1'b1;
              nxt.fresh      = 1'b1;
              nxt.good_count = cur.good_count + COUNT_W'(1);
              nxt.phase      = PH_READY;
              accepted       = 1'b1;
            end
            nxt.request_time = now_ms;
          end
        end else if (period_ms != '0 && elapsed(now_ms, cur.request_time, period_ms)) begin
          nxt.request_time = now_ms;
          nxt.ready_time   = due_time;
          nxt.phase        = PH_CONV;
          started          = 1'b1;
        end
      end
      FN_REQUEST: begin
        if (cur.phase != PH_CONV) begin
          nxt.request_time = now_ms;
          nxt.ready_time   = due_time;
          nxt.phase        = PH_CONV;
          started          = 1'b1;
        end
      end
      FN_READ: begin
        nxt.fresh = 1'b0;
      end
      default: begin
        // unused selector leaves the state alone
      end
    endcase
  end

  always_comb begin
    res.phase            = nxt.phase;
    res.start_conversion = started;
    res.sample_accepted  = accepted;
    res.temp_value       = nxt.last_temp;
    res.value_valid      = nxt.have_value;
    res.fresh            = nxt.fresh;
    res.good_count       = nxt.good_count;
    res.error_count      = nxt.error_count;
  end

endmodule

/* rtl/core/temp_sensor_sample_scheduler_core.sv */
// top level of the temperature sample scheduler: state, config and output stage
// depends on tsss_pkg and tsss_step
//
// usage
// - input channel in_*: one item per handshake, in_tuser carries the selector
//   (poll, request, read), in_tdata the timestamp and the sensor sample
// - output channel out_*: exactly one result item for every input item, in order
// - config channel cfg_*: always ready, index 0 period in ms (0 = no periodic
//   sampling), index 1 resolution, clamped to 9..12; write only while idle
// - the result is registered in the output register before it appears on out_*
// - throughput: one item per cycle while in_tready is high; the state update is a single pass through
//   32-bit adds and two wrap-safe compares, so the next item sees it at once
// - a stalled receiver fills the output register and then a skid register;
//   in_tready drops only while the skid register holds an item
// - reset (rst_n low, synchronous) returns the phase to idle, clears the stored
//   value, flags and counters, sets period to 0 and resolution to 12, and
//   empties the output stage

module temp_sensor_sample_scheduler_core
  import tsss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // now_ms [31:0], sample_temp [43:32], zero [47:44]
  input  logic [1:0]  in_tuser,   // func [1:0]

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // phase [1:0], start_conversion [2], sample_accepted [3],
                                  // temp_value [15:4], value_valid [16], fresh [17],
                                  // good_count [49:18], error_count [81:50], zero [87:82]

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [30:0] cfg_data
);

  tsss_state_t          state_r;
  tsss_state_t          state_nxt;
  tsss_result_t         step_res;
  logic [PERIOD_W-1:0]  period_r;
  logic [RES_W-1:0]     res_bits_r;

  tsss_result_t         out_r;
  logic                 out_valid_r;
  tsss_result_t         skid_r;
  logic                 skid_valid_r;

  logic                 in_acc;
  logic                 out_free;

  assign in_tready = !skid_valid_r;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  // output register can take a new item this cycle
  assign out_free  = !out_valid_r || out_tready;

  tsss_step u_step (
    .cur             (state_r),
    .period_ms       (period_r),
    .resolution_bits (res_bits_r),
    .func            (in_tuser),
    .now_ms          (in_tdata[31:0]),
    .sample_temp     (in_tdata[43:32]),
    .nxt             (state_nxt),
    .res             (step_res)
  );

  // scheduler state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= '0;
      period_r   <= '0;
      res_bits_r <= RES_RESET;
    end else begin
      if (in_acc) begin
        state_r <= state_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PERIOD:     period_r   <= cfg_data;
          CFG_RESOLUTION: res_bits_r <= clamp_res(cfg_data[RES_W-1:0]);
          default:        ;
        endcase
      end
    end
  end

  // output register plus skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= in_acc;
        end
      end else if (in_acc) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_valid_r ? skid_r : step_res;
    end
    if (in_acc && !out_free) begin
      skid_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_r};

endmodule

/* rtl/core/tsss_checker.sv */
// port-level checks for the temperature sample scheduler, with its bind
// depends on tsss_pkg and the temp_sensor_sample_scheduler_core ports

module tsss_checker
  import tsss_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [87:0] out_tdata
);

  // output stage empties on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // a started conversion leaves the block converting
  a_start_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[1:0] == PH_CONV && !out_tdata[3])
    else $error("conversion started but phase not converting");

  // a taken sample means ready, valid and fresh
  a_accept_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> out_tdata[1:0] == PH_READY && out_tdata[16] && out_tdata[17])
    else $error("sample taken without ready, valid and fresh");

  // fresh never without a stored value
  a_fresh_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[17] |-> out_tdata[16])
    else $error("fresh set with no stored value");

endmodule

bind temp_sensor_sample_scheduler_core tsss_checker u_tsss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
